@@ rtl/link_keepalive_fsm_defines.svh @@
// assertion macros shared by the link keepalive checker
// each macro expects clk and rst in scope of the module that uses it
`ifndef LINK_KEEPALIVE_FSM_DEFINES_SVH
`define LINK_KEEPALIVE_FSM_DEFINES_SVH

// same-cycle implication, quiet while reset is high
`define LKF_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, quiet while reset is high
`define LKF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// next-cycle implication that also watches the reset cycles
`define LKF_ASSERT_RESET(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/lkf_pkg.sv @@
// shared types, codes and divider constants for the link keepalive block
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps
`default_nettype none

package lkf_pkg;

  // local clock ticks in one second (100 ns units)
  localparam int unsigned TICKS_PER_SECOND = 10000000;

  // default depth of the queue between front and back
  localparam int unsigned QUEUE_DEPTH_DEF = 8;

  // configuration port
  localparam int unsigned CFG_INDEX_W = 1;
  localparam int unsigned CFG_DATA_W  = 16;
  localparam logic [CFG_INDEX_W-1:0] REG_MAX_MISSED = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_MAX_DRIFT  = 1'd1;
  localparam logic [7:0]  MAX_MISSED_RST = 8'd3;
  localparam logic [15:0] MAX_DRIFT_RST  = 16'd2;

  // commands
  localparam logic [2:0] CMD_CONNECT     = 3'd0;
  localparam logic [2:0] CMD_SHUTDOWN    = 3'd1;
  localparam logic [2:0] CMD_BREAK       = 3'd2;
  localparam logic [2:0] CMD_MESSAGE     = 3'd3;
  localparam logic [2:0] CMD_ALIVE_REQ   = 3'd4;
  localparam logic [2:0] CMD_WAIT_EXPIRY = 3'd5;
  localparam logic [2:0] CMD_SYNC        = 3'd6;

  // result codes
  localparam logic [1:0] LS_IDLE         = 2'd0;
  localparam logic [1:0] LS_CONNECTED    = 2'd2;
  localparam logic [1:0] LS_RECONNECT    = 2'd3;
  localparam logic [1:0] SS_WAITING      = 2'd0;
  localparam logic [1:0] SS_CONNECTED    = 2'd1;
  localparam logic [1:0] SS_DEGRADED     = 2'd2;
  localparam logic [1:0] WT_NONE         = 2'd0;
  localparam logic [1:0] WT_RESTART      = 2'd1;
  localparam logic [1:0] WT_STOP         = 2'd2;
  localparam logic [1:0] RT_NONE         = 2'd0;
  localparam logic [1:0] RT_START        = 2'd1;
  localparam logic [1:0] RT_STOP         = 2'd2;
  localparam logic [1:0] LINK_NONE       = 2'd0;
  localparam logic [1:0] LINK_CONNECT    = 2'd1;
  localparam logic [1:0] LINK_DISCONNECT = 2'd2;
  localparam logic [1:0] MSG_NONE        = 2'd0;
  localparam logic [1:0] MSG_ALIVE_REQ   = 2'd1;
  localparam logic [1:0] MSG_ALIVE_REPLY = 2'd2;

  // saturated offsets
  localparam logic signed [31:0] OFFSET_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] OFFSET_MIN = 32'sh8000_0000;

  // reciprocal divide: magnitudes below SAT_LIMIT fit in MAG_W bits and
  // floor(x / TICKS) == (x * RECIP) >> RECIP_SHIFT holds for all of them
  localparam int unsigned MAG_W       = 55;
  localparam int unsigned PP_W        = 28;
  localparam int unsigned RECIP_SHIFT = 79;
  localparam int unsigned Q_SHIFT     = RECIP_SHIFT - 2 * PP_W;
  localparam logic [63:0] SAT_LIMIT   = 64'(TICKS_PER_SECOND) << 31;
  localparam logic [79:0] RECIP_WIDE  =
    ((80'd1 << RECIP_SHIFT) + 80'(TICKS_PER_SECOND) - 80'd1) / 80'(TICKS_PER_SECOND);
  localparam logic [55:0] RECIP       = 56'(RECIP_WIDE);
  localparam logic [27:0] RECIP_HI    = 28'(RECIP >> PP_W);
  localparam logic [27:0] RECIP_LO    = 28'(RECIP);

  typedef struct packed {
    logic [2:0]  command;
    logic        connect_ok;
    logic [63:0] message_time;
    logic [63:0] current_time;
  } lkf_in_t;

  typedef struct packed {
    logic [1:0]         link_state;
    logic [1:0]         server_status;
    logic               time_link_ok;
    logic [1:0]         wait_timer_action;
    logic [1:0]         reconnect_timer_action;
    logic [1:0]         link_action;
    logic [1:0]         send_message;
    logic               send_time_update;
    logic signed [31:0] time_difference;
    logic               event_accepted;
  } lkf_out_t;

  // classified event handed from front to back
  typedef struct packed {
    logic [2:0]         command;
    logic               connect_ok;
    logic signed [31:0] offset;
  } lkf_evt_t;

  typedef enum logic [2:0] {
    PH_IDLE      = 3'b001,
    PH_CONNECTED = 3'b010,
    PH_RECONNECT = 3'b100
  } lkf_phase_t;

endpackage

`default_nettype wire

@@ rtl/lkf_front.sv @@
// front end: takes input items, works out the clock offset in seconds
// through a six-stage reciprocal-divide pipeline; uses lkf_pkg
`timescale 1ns / 1ps
`default_nettype none

module lkf_front import lkf_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  lkf_in_t  in_item,
  input  logic     pop,
  output logic     evt_valid,
  output lkf_evt_t evt
);

  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [CNT_W-1:0] inflight;
  logic             take;

  logic [63:0] diff_fwd;
  logic [63:0] diff_rev;

  logic        s1_valid, s2_valid, s3_valid, s4_valid, s5_valid, s6_valid;
  logic [2:0]  s1_cmd, s2_cmd, s3_cmd, s4_cmd, s5_cmd, s6_cmd;
  logic        s1_ok, s2_ok, s3_ok, s4_ok, s5_ok, s6_ok;
  logic        s1_neg, s2_neg, s3_neg, s4_neg, s5_neg;
  logic        s2_over, s3_over, s4_over, s5_over;
  logic [63:0] s1_mag;
  logic [54:0] s2_phh, s3_phh, s4_phh;
  logic [54:0] s2_phl;
  logic [55:0] s2_plh;
  logic [55:0] s2_pll, s3_pll;
  logic [56:0] s3_mid;
  logic [29:0] s4_lo_hi;
  logic [30:0] s5_q;
  logic signed [31:0] s6_offset;

  logic [26:0] x_hi;
  logic [27:0] x_lo;
  logic [85:0] lo_sum;
  logic [55:0] top_sum;
  logic [31:0] q_ext;

  // credit count: items accepted and not yet taken by the back end
  assign in_ready = (inflight < CNT_W'(QUEUE_DEPTH));
  assign take     = in_valid & in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      inflight <= '0;
    end else if (take && !pop) begin
      inflight <= inflight + 1'b1;
    end else if (!take && pop) begin
      inflight <= inflight - 1'b1;
    end
  end

  // valid bits of the pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      s4_valid <= 1'b0;
      s5_valid <= 1'b0;
      s6_valid <= 1'b0;
    end else begin
      s1_valid <= take;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
      s4_valid <= s3_valid;
      s5_valid <= s4_valid;
      s6_valid <= s5_valid;
    end
  end

  // stage 1: signed tick difference as sign and magnitude
  assign diff_fwd = in_item.current_time - in_item.message_time;
  assign diff_rev = in_item.message_time - in_item.current_time;

  always_ff @(posedge clk) begin
    s1_cmd <= in_item.command;
    s1_ok  <= in_item.connect_ok;
    s1_neg <= diff_fwd[63];
    s1_mag <= diff_fwd[63] ? diff_rev : diff_fwd;
  end

  // stage 2: saturation check and partial products with the reciprocal
  assign x_hi = s1_mag[MAG_W-1:PP_W];
  assign x_lo = s1_mag[PP_W-1:0];

  always_ff @(posedge clk) begin
    s2_cmd  <= s1_cmd;
    s2_ok   <= s1_ok;
    s2_neg  <= s1_neg;
    s2_over <= (s1_mag >= SAT_LIMIT);
    s2_phh  <= 55'(x_hi) * 55'(RECIP_HI);
    s2_phl  <= 55'(x_hi) * 55'(RECIP_LO);
    s2_plh  <= 56'(x_lo) * 56'(RECIP_HI);
    s2_pll  <= 56'(x_lo) * 56'(RECIP_LO);
  end

  // stage 3: sum the two middle products
  always_ff @(posedge clk) begin
    s3_cmd  <= s2_cmd;
    s3_ok   <= s2_ok;
    s3_neg  <= s2_neg;
    s3_over <= s2_over;
    s3_phh  <= s2_phh;
    s3_pll  <= s2_pll;
    s3_mid  <= 57'(s2_phl) + 57'(s2_plh);
  end

  // stage 4: fold the low product in, keep bit 56 and the bits above it
  assign lo_sum = 86'(s3_pll) + 86'({s3_mid, 28'd0});

  always_ff @(posedge clk) begin
    s4_cmd   <= s3_cmd;
    s4_ok    <= s3_ok;
    s4_neg   <= s3_neg;
    s4_over  <= s3_over;
    s4_phh   <= s3_phh;
    s4_lo_hi <= lo_sum[85:56];
  end

  // stage 5: quotient of magnitude by ticks per second
  assign top_sum = 56'(s4_phh) + 56'(s4_lo_hi);

  always_ff @(posedge clk) begin
    s5_cmd  <= s4_cmd;
    s5_ok   <= s4_ok;
    s5_neg  <= s4_neg;
    s5_over <= s4_over;
    s5_q    <= top_sum[Q_SHIFT +: 31];
  end

  // stage 6: negate and saturate to the reported offset
  assign q_ext = {1'b0, s5_q};

  always_ff @(posedge clk) begin
    s6_cmd <= s5_cmd;
    s6_ok  <= s5_ok;
    if (s5_over) begin
      s6_offset <= s5_neg ? OFFSET_MAX : OFFSET_MIN;
    end else if (s5_neg) begin
      s6_offset <= $signed(q_ext);
    end else begin
      s6_offset <= $signed(32'd0 - q_ext);
    end
  end

  assign evt_valid      = s6_valid;
  assign evt.command    = s6_cmd;
  assign evt.connect_ok = s6_ok;
  assign evt.offset     = s6_offset;

endmodule

`default_nettype wire

@@ rtl/lkf_queue.sv @@
// small fifo of classified events between front and back
// uses lkf_pkg; never overfills since the front holds a credit per entry
`timescale 1ns / 1ps
`default_nettype none

module lkf_queue import lkf_pkg::*; #(
  parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  lkf_evt_t push_evt,
  input  logic     pop,
  output logic     head_valid,
  output lkf_evt_t head_evt
);

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  lkf_evt_t         entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_evt;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (!push && pop) begin
        count <= count - 1'b1;
      end
    end
  end

  assign head_valid = (count != '0);
  assign head_evt   = entries[rd_ptr];

endmodule

`default_nettype wire

@@ rtl/lkf_back.sv @@
// back end: link state machine, missed-alive counter, drift check,
// configuration registers and the result register; uses lkf_pkg
`timescale 1ns / 1ps
`default_nettype none

module lkf_back import lkf_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   evt_valid,
  input  lkf_evt_t               evt,
  output logic                   pop,
  output logic                   out_valid,
  input  logic                   out_ready,
  output lkf_out_t               out_item
);

  localparam logic [8:0] COUNT_MAX = 9'd511;

  lkf_phase_t         phase, phase_next;
  logic [8:0]         missed, missed_next;
  logic signed [31:0] stored, stored_next;
  logic [1:0]         status, status_next;
  logic               tl_up, tl_up_next;
  logic [7:0]         max_missed;
  logic [15:0]        max_drift;

  logic               limit_hit;
  logic [8:0]         missed_inc;
  logic signed [32:0] d_up;
  logic signed [32:0] d_dn;
  logic signed [32:0] tol;
  logic               drifted;
  lkf_out_t           res;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      max_missed <= MAX_MISSED_RST;
      max_drift  <= MAX_DRIFT_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_MAX_MISSED: max_missed <= cfg_data[7:0];
        REG_MAX_DRIFT:  max_drift  <= cfg_data;
        default: ;
      endcase
    end
  end

  // take the head event when the result register is free
  assign pop = evt_valid && (!out_valid || out_ready);

  // missed-alive counter helpers
  assign limit_hit  = (missed >= {1'b0, max_missed});
  assign missed_inc = (missed != COUNT_MAX) ? missed + 1'b1 : missed;

  // drift check: |stored - offset| > max_drift
  assign d_up    = {stored[31], stored} - {evt.offset[31], evt.offset};
  assign d_dn    = {evt.offset[31], evt.offset} - {stored[31], stored};
  assign tol     = $signed({17'd0, max_drift});
  assign drifted = (d_up > tol) || (d_dn > tol);

  // event decode and next state
  always_comb begin
    phase_next  = phase;
    missed_next = missed;
    stored_next = stored;
    status_next = status;
    tl_up_next  = tl_up;

    res.link_state             = LS_IDLE;
    res.server_status          = SS_WAITING;
    res.time_link_ok           = 1'b0;
    res.wait_timer_action      = WT_NONE;
    res.reconnect_timer_action = RT_NONE;
    res.link_action            = LINK_NONE;
    res.send_message           = MSG_NONE;
    res.send_time_update       = 1'b0;
    res.time_difference        = '0;
    res.event_accepted         = 1'b0;

    unique case (evt.command) inside
      CMD_SHUTDOWN: begin
        res.event_accepted         = 1'b1;
        status_next                = SS_WAITING;
        tl_up_next                 = 1'b0;
        res.link_action            = LINK_DISCONNECT;
        res.wait_timer_action      = WT_STOP;
        res.reconnect_timer_action = RT_STOP;
        phase_next                 = PH_IDLE;
      end
      CMD_CONNECT: begin
        if (phase == PH_IDLE || phase == PH_RECONNECT) begin
          res.event_accepted = 1'b1;
          res.link_action    = LINK_CONNECT;
          if (evt.connect_ok) begin
            missed_next           = '0;
            status_next           = SS_CONNECTED;
            tl_up_next            = 1'b1;
            res.wait_timer_action = WT_RESTART;
            phase_next            = PH_CONNECTED;
          end else begin
            status_next                = SS_DEGRADED;
            tl_up_next                 = 1'b0;
            res.reconnect_timer_action = RT_START;
            phase_next                 = PH_RECONNECT;
          end
        end
      end
      CMD_BREAK: begin
        if (phase == PH_CONNECTED) begin
          res.event_accepted         = 1'b1;
          status_next                = SS_DEGRADED;
          tl_up_next                 = 1'b0;
          res.link_action            = LINK_DISCONNECT;
          res.wait_timer_action      = WT_STOP;
          res.reconnect_timer_action = RT_START;
          phase_next                 = PH_RECONNECT;
        end
      end
      CMD_MESSAGE, CMD_ALIVE_REQ: begin
        if (phase == PH_CONNECTED) begin
          res.event_accepted    = 1'b1;
          missed_next           = '0;
          res.wait_timer_action = WT_RESTART;
          if (evt.command == CMD_ALIVE_REQ) begin
            res.send_message = MSG_ALIVE_REPLY;
          end
          if (drifted) begin
            stored_next          = evt.offset;
            res.send_time_update = 1'b1;
            res.time_difference  = evt.offset;
          end
        end
      end
      CMD_WAIT_EXPIRY: begin
        if (phase == PH_CONNECTED) begin
          res.event_accepted = 1'b1;
          missed_next        = missed_inc;
          if (limit_hit) begin
            // too many unanswered alive requests: drop the link
            status_next                = SS_DEGRADED;
            tl_up_next                 = 1'b0;
            res.link_action            = LINK_DISCONNECT;
            res.wait_timer_action      = WT_STOP;
            res.reconnect_timer_action = RT_START;
            phase_next                 = PH_RECONNECT;
          end else begin
            res.wait_timer_action = WT_RESTART;
            res.send_message      = MSG_ALIVE_REQ;
          end
        end
      end
      CMD_SYNC: begin
        if (phase == PH_CONNECTED) begin
          res.event_accepted   = 1'b1;
          res.send_time_update = 1'b1;
          res.time_difference  = stored;
        end
      end
      default: ;
    endcase

    unique case (phase_next)
      PH_IDLE:      res.link_state = LS_IDLE;
      PH_CONNECTED: res.link_state = LS_CONNECTED;
      PH_RECONNECT: res.link_state = LS_RECONNECT;
      default:      res.link_state = LS_IDLE;
    endcase
    res.server_status = status_next;
    res.time_link_ok  = tl_up_next;
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase  <= PH_IDLE;
      missed <= '0;
      stored <= '0;
      status <= SS_WAITING;
      tl_up  <= 1'b0;
    end else if (pop) begin
      phase  <= phase_next;
      missed <= missed_next;
      stored <= stored_next;
      status <= status_next;
      tl_up  <= tl_up_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_item <= res;
    end
  end

endmodule

`default_nettype wire

@@ rtl/link_keepalive_fsm.sv @@
// top level of the link keepalive supervisor: front, event queue, back
// throughput: one item per cycle while out_ready is high; the six-stage
// offset pipeline and the state update in the back each take an item every cycle
// up to QUEUE_DEPTH items in flight; depends on lkf_pkg and its submodules
// synchronous reset: idle, counters clear, registers to defaults, no sweep
`timescale 1ns / 1ps
`default_nettype none

module link_keepalive_fsm import lkf_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  lkf_in_t                in_item,
  output logic                   out_valid,
  input  logic                   out_ready,
  output lkf_out_t               out_item
);

  logic     evt_valid;
  lkf_evt_t evt;
  logic     head_valid;
  lkf_evt_t head_evt;
  logic     pop;

  // offset pipeline and credit control
  lkf_front #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .pop      (pop),
    .evt_valid(evt_valid),
    .evt      (evt)
  );

  // decoupling queue
  lkf_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (evt_valid),
    .push_evt  (evt),
    .pop       (pop),
    .head_valid(head_valid),
    .head_evt  (head_evt)
  );

  // state machine and result register
  lkf_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .evt_valid(head_valid),
    .evt      (head_evt),
    .pop      (pop),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_item (out_item)
  );

endmodule

`default_nettype wire

@@ rtl/lkf_checker.sv @@
// port-level checks on the link keepalive supervisor, bound to the top
// depends on lkf_pkg and link_keepalive_fsm_defines.svh
`timescale 1ns / 1ps
`default_nettype none
`include "link_keepalive_fsm_defines.svh"

module lkf_checker import lkf_pkg::*; (
  input logic     clk,
  input logic     rst,
  input logic     in_ready,
  input logic     out_valid,
  input logic     out_ready,
  input lkf_out_t out_item
);

  // reset leaves no result pending and the input open
  `LKF_ASSERT_RESET(a_reset_clears, rst, !out_valid && in_ready, "reset did not clear output")

  // a stalled result item holds
  `LKF_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_item), "stalled result changed")

  // connected state, connected status and time link up go together
  `LKF_ASSERT_NOW(a_link_status, out_valid, ((out_item.link_state == LS_CONNECTED) == (out_item.server_status == SS_CONNECTED)) && ((out_item.link_state == LS_CONNECTED) == out_item.time_link_ok), "link state and status disagree")

  // a refused event triggers no action
  `LKF_ASSERT_NOW(a_refused_quiet, out_valid && !out_item.event_accepted, out_item.link_action == LINK_NONE && out_item.send_message == MSG_NONE && out_item.wait_timer_action == WT_NONE && out_item.reconnect_timer_action == RT_NONE && !out_item.send_time_update, "refused event produced an action")

endmodule

bind link_keepalive_fsm lkf_checker u_checker (
  .clk      (clk),
  .rst      (rst),
  .in_ready (in_ready),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .out_item (out_item)
);

`default_nettype wire
